// File: rtl/core/itpl_pkg.sv
package itpl_pkg;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_NODE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SCORE   = 2'd2;

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TREES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 1'd1;

	localparam int TREES_W = 8;
	localparam int STEP_W  = 4;
	localparam logic [TREES_W-1:0] TREES_RESET = 8'd100;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 4'd15;

	localparam int SUM_W = 20;
	localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;
	localparam int ACC_W = SUM_W + 2;
	localparam int C_W   = 16;

	localparam logic [63:0] GAMMA_Q28 = 64'd154945150;
	localparam logic [63:0] LN2_Q32   = 64'd2977044472;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [6:0]         tree_number;
		logic [8:0]         node_number;
		logic               node_is_leaf;
		logic [9:0]         split_feature;
		logic signed [15:0] split_threshold;
		logic [8:0]         left_slot;
		logic [8:0]         right_slot;
		logic [3:0]         leaf_depth;
		logic [8:0]         leaf_count;
		logic [9:0]         feature_slot;
		logic signed [15:0] feature_value;
	} in_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] path_length_sum;
		logic             walk_error;
	} out_item_t;

	typedef struct packed {
		logic [8:0]         leaf_count;
		logic [3:0]         leaf_depth;
		logic [8:0]         right_slot;
		logic [8:0]         left_slot;
		logic signed [15:0] split_threshold;
		logic [9:0]         split_feature;
		logic               is_leaf;
	} node_t;

	typedef struct packed {
		logic start;
		logic node_wr;
		logic feat_wr;
		logic node_rd;
		logic feat_rd;
		logic step;
		logic leaf_latch;
		logic tree_add;
		logic tree_fail;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic trees_done;
		logic is_leaf;
		logic step_over;
		logic child_bad;
	} status_t;

	// binary log in Q.28 by repeated squaring
	function automatic logic [63:0] log2_q28(input logic [31:0] m);
		logic [5:0]  k;
		logic [63:0] y;
		logic [63:0] res;
		k = '0;
		for (int i = 0; i < 31; i++) begin
			if ((m >> (i + 1)) != 32'd0) begin
				k = 6'(i + 1);
			end
		end
		y = ({32'd0, m} << 30) >> k;
		res = 64'(k) << 28;
		for (int i = 27; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				res = res | (64'd1 << i);
			end
		end
		return res;
	endfunction

	// average unsuccessful search length c(n), Q.8, rounded half up
	function automatic logic [C_W-1:0] c_q8(input int unsigned n);
		logic [63:0] ln;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] v;
		if (n < 2) begin
			return '0;
		end
		if (n == 2) begin
			return C_W'(256);
		end
		ln = (log2_q28(32'(n - 1)) * LN2_Q32) >> 32;
		num = 64'(2 * (n - 1)) << 28;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= 64'(n)) begin
				rem = rem - 64'(n);
				quo[i] = 1'b1;
			end
		end
		v = (ln << 1) + (GAMMA_Q28 << 1) - quo;
		return C_W'((v + (64'd1 << 19)) >> 20);
	endfunction

endpackage

// File: rtl/core/itpl_ctrl.sv
module itpl_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic [itpl_pkg::KIND_W-1:0]    kind,
	output logic                           item_stall,
	output logic                           result_valid,
	input  logic                           result_stall,
	input  itpl_pkg::status_t              status,
	output itpl_pkg::cmd_t                 cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TREE = 3'd1;
	localparam logic [2:0] S_NODE = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       result_valid_q;
	logic       accept;
	logic       can_load;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign can_load     = !result_valid_q || !result_stall;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.node_wr = accept && (kind == itpl_pkg::KIND_NODE);
				cmd.feat_wr = accept && (kind == itpl_pkg::KIND_FEATURE);
				if (accept && (kind == itpl_pkg::KIND_SCORE)) begin
					cmd.start  = 1'b1;
					state_next = S_TREE;
				end
			end
			S_TREE: begin
				if (status.trees_done) begin
					if (can_load) begin
						cmd.load_result = 1'b1;
						state_next      = S_IDLE;
					end
				end else begin
					cmd.node_rd = 1'b1;
					state_next  = S_NODE;
				end
			end
			S_NODE: begin
				priority if (status.is_leaf) begin
					cmd.leaf_latch = 1'b1;
					state_next     = S_ADD;
				end else if (status.step_over) begin
					cmd.tree_fail = 1'b1;
					state_next    = S_TREE;
				end else begin
					cmd.feat_rd = 1'b1;
					state_next  = S_CMP;
				end
			end
			S_CMP: begin
				if (status.child_bad) begin
					cmd.tree_fail = 1'b1;
					state_next    = S_TREE;
				end else begin
					cmd.step    = 1'b1;
					cmd.node_rd = 1'b1;
					state_next  = S_NODE;
				end
			end
			S_ADD: begin
				cmd.tree_add = 1'b1;
				state_next   = S_TREE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/itpl_dp.sv
module itpl_dp #(
	parameter int MAX_TREES      = 128,
	parameter int NODES_PER_TREE = 512,
	parameter int MAX_FEATURES   = 1024,
	parameter int MAX_LEAF_COUNT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [itpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [itpl_pkg::CFG_W-1:0]       cfg_data,
	input  itpl_pkg::in_item_t               item,
	input  itpl_pkg::cmd_t                   cmd,
	output itpl_pkg::status_t                status,
	output itpl_pkg::out_item_t              result
);

	localparam int NODE_DEPTH = MAX_TREES * NODES_PER_TREE;
	localparam int AW  = $clog2(NODE_DEPTH);
	localparam int SW  = $clog2(NODES_PER_TREE);
	localparam int TCW = $clog2(MAX_TREES + 1);
	localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CIW = $clog2(MAX_LEAF_COUNT + 1);
	localparam int ACC_SUM_W = itpl_pkg::ACC_W;

	itpl_pkg::node_t node_mem [0:NODE_DEPTH-1];
	logic signed [15:0] feat_mem [0:MAX_FEATURES-1];
	logic [itpl_pkg::C_W-1:0] c_rom [0:MAX_LEAF_COUNT];

	for (genvar n = 0; n <= MAX_LEAF_COUNT; n++) begin : g_c_rom
		localparam logic [itpl_pkg::C_W-1:0] CV = itpl_pkg::c_q8(n);
		assign c_rom[n] = CV;
	end

	logic [itpl_pkg::TREES_W-1:0] trees_in_use_q;
	logic [itpl_pkg::STEP_W-1:0]  step_limit_q;
	logic [TCW-1:0]               tree_q;
	logic [SW-1:0]                slot_q;
	logic [itpl_pkg::STEP_W-1:0]  splits_q;
	logic [itpl_pkg::SUM_W-1:0]   sum_q;
	logic                         err_q;
	itpl_pkg::node_t              node_q;
	logic signed [15:0]           feat_q;
	logic                         feat_ok_q;
	logic [itpl_pkg::C_W-1:0]     c_q;
	logic [3:0]                   depth_q;
	itpl_pkg::out_item_t          result_q;

	logic [AW-1:0]            wr_addr;
	logic [AW-1:0]            rd_addr;
	logic                     node_wr_ok;
	logic                     feat_wr_ok;
	int unsigned              ntrees;
	logic signed [15:0]       fv;
	logic [8:0]               child;
	logic [SW-1:0]            rd_slot;
	logic [8:0]               cnt_clip;
	logic [ACC_SUM_W-1:0]     acc;

	assign node_wr_ok = cmd.node_wr && (32'(item.tree_number) < MAX_TREES)
		&& (32'(item.node_number) < NODES_PER_TREE);
	assign feat_wr_ok = cmd.feat_wr && (32'(item.feature_slot) < MAX_FEATURES);
	assign wr_addr = AW'(32'(item.tree_number) * NODES_PER_TREE + 32'(item.node_number));

	assign fv    = feat_ok_q ? feat_q : 16'sd0;
	assign child = (fv < node_q.split_threshold) ? node_q.left_slot : node_q.right_slot;
	assign rd_slot = cmd.step ? SW'(child) : slot_q;
	assign rd_addr = AW'(32'(tree_q) * NODES_PER_TREE + 32'(rd_slot));

	assign ntrees = (32'(trees_in_use_q) > MAX_TREES) ? MAX_TREES : 32'(trees_in_use_q);
	assign cnt_clip = (32'(node_q.leaf_count) > MAX_LEAF_COUNT) ? 9'(MAX_LEAF_COUNT)
		: node_q.leaf_count;

	assign acc = ACC_SUM_W'(sum_q) + ACC_SUM_W'({depth_q, 8'h00}) + ACC_SUM_W'(c_q);

	assign status.trees_done = (32'(tree_q) >= ntrees);
	assign status.is_leaf    = node_q.is_leaf;
	assign status.step_over  = (splits_q >= step_limit_q);
	assign status.child_bad  = (32'(child) >= NODES_PER_TREE);

	assign result = result_q;

	// memories
	always_ff @(posedge clk) begin
		if (node_wr_ok) begin
			node_mem[wr_addr] <= '{
				leaf_count:      item.leaf_count,
				leaf_depth:      item.leaf_depth,
				right_slot:      item.right_slot,
				left_slot:       item.left_slot,
				split_threshold: item.split_threshold,
				split_feature:   item.split_feature,
				is_leaf:         item.node_is_leaf
			};
		end
		if (cmd.node_rd) begin
			node_q <= node_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (feat_wr_ok) begin
			feat_mem[FAW'(item.feature_slot)] <= item.feature_value;
		end
		if (cmd.feat_rd) begin
			feat_q    <= feat_mem[FAW'(node_q.split_feature)];
			feat_ok_q <= (32'(node_q.split_feature) < MAX_FEATURES);
		end
	end

	// leaf term and result
	always_ff @(posedge clk) begin
		if (cmd.leaf_latch) begin
			c_q     <= c_rom[CIW'(cnt_clip)];
			depth_q <= node_q.leaf_depth;
		end
		if (cmd.load_result) begin
			result_q.path_length_sum <= sum_q;
			result_q.walk_error      <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trees_in_use_q <= itpl_pkg::TREES_RESET;
			step_limit_q   <= itpl_pkg::STEP_RESET;
			tree_q         <= '0;
			slot_q         <= '0;
			splits_q       <= '0;
			sum_q          <= '0;
			err_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					itpl_pkg::REG_TREES_IN_USE: trees_in_use_q <= cfg_data;
					itpl_pkg::REG_STEP_LIMIT:   step_limit_q   <= cfg_data[itpl_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
			priority if (cmd.start) begin
				tree_q   <= '0;
				slot_q   <= '0;
				splits_q <= '0;
				sum_q    <= '0;
				err_q    <= 1'b0;
			end else if (cmd.tree_fail) begin
				tree_q   <= tree_q + 1'b1;
				slot_q   <= '0;
				splits_q <= '0;
				err_q    <= 1'b1;
			end else if (cmd.tree_add) begin
				tree_q   <= tree_q + 1'b1;
				slot_q   <= '0;
				splits_q <= '0;
				sum_q    <= (acc > ACC_SUM_W'(itpl_pkg::SUM_MAX)) ? itpl_pkg::SUM_MAX
					: acc[itpl_pkg::SUM_W-1:0];
			end else if (cmd.step) begin
				slot_q <= SW'(child);
			end else if (cmd.feat_rd) begin
				splits_q <= splits_q + 1'b1;
			end else begin
				slot_q <= slot_q;
			end
		end
	end

endmodule

// File: rtl/core/isolation_tree_path_length.sv
// channel  | payload                   | handshake
// item     | itpl_pkg::in_item_t       | item_valid / item_stall
// result   | itpl_pkg::out_item_t      | result_valid / result_stall
// config   | cfg_index, cfg_data       | cfg_we
//
// node and feature writes complete in the idle state and do not stall the item channel
// a score walks each tree from its root, one node read and one feature read per split level,
//   until it reaches a leaf, the step limit stops it or a child slot is out of range;
//   the final result load waits while a held result is stalled
// reset clears control state and sets config to its defaults only, tree and feature memories hold garbage
// a finished result waits in the output register while new items are taken
module isolation_tree_path_length #(
	parameter int MAX_TREES      = 128,
	parameter int NODES_PER_TREE = 512,
	parameter int MAX_FEATURES   = 1024,
	parameter int MAX_LEAF_COUNT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [itpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [itpl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  itpl_pkg::in_item_t               item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output itpl_pkg::out_item_t              result
);

	itpl_pkg::cmd_t    cmd;
	itpl_pkg::status_t status;

	itpl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.kind         (item.kind),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	itpl_dp #(
		.MAX_TREES      (MAX_TREES),
		.NODES_PER_TREE (NODES_PER_TREE),
		.MAX_FEATURES   (MAX_FEATURES),
		.MAX_LEAF_COUNT (MAX_LEAF_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule
